>>> rtl/core/fractal_escape_iteration_unit_macros.svh
// Assertion helpers for the escape-time iteration unit.
`ifndef FRACTAL_ESCAPE_ITERATION_UNIT_MACROS_SVH
`define FRACTAL_ESCAPE_ITERATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FEI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FEI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/fei_pkg.sv
`timescale 1ns / 1ps

package fei_pkg;

   localparam int INT_BITS   = 3;
   localparam int FRAC_BITS  = 8;
   localparam int MAG_BITS   = INT_BITS + FRAC_BITS;
   localparam int FIELD_BITS = 12;
   localparam int COUNT_BITS = 8;
   localparam int GLYPH_BITS = 7;

   localparam logic [COUNT_BITS-1:0] MAX_ITER_RESET = 8'd250;

   typedef struct packed {
      logic [FIELD_BITS-1:0] c_real;
      logic [FIELD_BITS-1:0] c_imag;
      logic [FIELD_BITS-1:0] z_real;
      logic [FIELD_BITS-1:0] z_imag;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] iteration_count;
      logic [GLYPH_BITS-1:0] glyph_code;
   } rsp_type;

   // Sign-magnitude value with an overflow flag.
   typedef struct packed {
      logic                nan;
      logic                neg;
      logic [MAG_BITS-1:0] mag;
   } sm_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SQUARE
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      sm_type     a;
      sm_type     b;
   } alu_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_R,
      ST_INIT_I,
      ST_CHECK,
      ST_DIFF,
      ST_DSQ,
      ST_T1,
      ST_T2,
      ST_ZI,
      ST_R1,
      ST_ZR,
      ST_SQR,
      ST_SQI
   } state_type;

   localparam int GLYPH_COUNT = 19;
   localparam int GLYPH_IDX_BITS = $clog2(GLYPH_COUNT);

   localparam logic [GLYPH_BITS-1:0] GLYPH_SPACE = 7'h20;
   localparam logic [GLYPH_BITS-1:0] GLYPH_LAST  = 7'h23;

   // Palette " .,'~=+:;[/<*?&o0x#"
   localparam logic [GLYPH_BITS-1:0] GLYPH_TABLE [GLYPH_COUNT] = '{
      7'h20, 7'h2E, 7'h2C, 7'h27, 7'h7E, 7'h3D, 7'h2B, 7'h3A, 7'h3B, 7'h5B,
      7'h2F, 7'h3C, 7'h2A, 7'h3F, 7'h26, 7'h6F, 7'h30, 7'h78, 7'h23
   };

   function automatic sm_type sm_decode(input logic [FIELD_BITS-1:0] bits);
      sm_type r;
      r.nan = 1'b0;
      r.neg = bits[MAG_BITS];
      r.mag = bits[MAG_BITS-1:0];
      return r;
   endfunction

   function automatic sm_type sm_negate(input sm_type a);
      sm_type r;
      r     = a;
      r.neg = ~a.neg;
      return r;
   endfunction

   function automatic logic [GLYPH_BITS-1:0] glyph_for(input logic [COUNT_BITS-1:0] count);
      logic [COUNT_BITS-2:0] half;
      logic [COUNT_BITS-2:0] idx;
      half = count[COUNT_BITS-1:1];
      idx  = half - (COUNT_BITS-1)'(3);
      if (half < (COUNT_BITS-1)'(3)) begin
         return GLYPH_SPACE;
      end
      if (idx >= (COUNT_BITS-1)'(GLYPH_COUNT)) begin
         return GLYPH_LAST;
      end
      return GLYPH_TABLE[idx[GLYPH_IDX_BITS-1:0]];
   endfunction

endpackage

>>> rtl/core/fei_alu.sv
`timescale 1ns / 1ps

module fei_alu (
   input  fei_pkg::alu_req_type alu_req,
   output fei_pkg::sm_type      alu_res
);
   import fei_pkg::*;

   localparam int PROD_BITS = 2 * MAG_BITS;
   localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS+1)'(1) << (FRAC_BITS - 1);

   logic [PROD_BITS-1:0] prod;
   logic [PROD_BITS:0]   prod_round;
   logic [PROD_BITS:0]   prod_shift;
   logic [MAG_BITS:0]    mag_sum;
   sm_type               sq_res;
   sm_type               add_res;

   // Square: round to nearest, flag overflow.
   always_comb begin
      prod       = {{MAG_BITS{1'b0}}, alu_req.a.mag} * {{MAG_BITS{1'b0}}, alu_req.a.mag};
      prod_round = {1'b0, prod} + ROUND_HALF;
      prod_shift = prod_round >> FRAC_BITS;
      sq_res.nan = alu_req.a.nan || (|prod_shift[PROD_BITS:MAG_BITS]);
      sq_res.neg = 1'b0;
      sq_res.mag = prod_shift[MAG_BITS-1:0];
   end

   // Sign-magnitude add; ties keep the first operand's sign.
   always_comb begin
      mag_sum     = {1'b0, alu_req.a.mag} + {1'b0, alu_req.b.mag};
      add_res.nan = alu_req.a.nan || alu_req.b.nan;
      if (alu_req.a.neg == alu_req.b.neg) begin
         add_res.nan = add_res.nan || mag_sum[MAG_BITS];
         add_res.neg = alu_req.a.neg;
         add_res.mag = mag_sum[MAG_BITS-1:0];
      end else if (alu_req.a.mag < alu_req.b.mag) begin
         add_res.neg = alu_req.b.neg;
         add_res.mag = alu_req.b.mag - alu_req.a.mag;
      end else begin
         add_res.neg = alu_req.a.neg;
         add_res.mag = alu_req.a.mag - alu_req.b.mag;
      end
   end

   always_comb begin
      case (alu_req.op)
         ALU_ADD:    alu_res = add_res;
         ALU_SQUARE: alu_res = sq_res;
         default:    alu_res = add_res;
      endcase
   end

endmodule

>>> rtl/core/fractal_escape_iteration_unit.sv
`timescale 1ns / 1ps
// A new item is taken only while idle; one shared add/square unit takes ten sequencer steps
//    per iteration. busy drops in the cycle the result strobe shows.
// Reset: synchronous, active high; returns to idle, drops the strobe, sets max_iter to 250.
// The receiver cannot stall: each result is flagged on rsp_valid for exactly one cycle.
module fractal_escape_iteration_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fei_pkg::req_type req_item,
   output logic             rsp_valid,
   output fei_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata
);
   import fei_pkg::*;

   // Sequencer state and iteration count
   state_type             state_ff;
   state_type             state_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] max_iter_ff;

   // Working values: constant, current z, its squares, and a scratch term
   sm_type cr_ff;
   sm_type ci_ff;
   sm_type zr_ff;
   sm_type zi_ff;
   sm_type zr2_ff;
   sm_type zi2_ff;
   sm_type t_ff;

   // Result register
   logic    rsp_valid_ff;
   rsp_type rsp_item_ff;

   alu_req_type alu_req;
   sm_type      alu_res;
   logic        check_exit;

   fei_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   // Leave the loop when the limit is reached or |z|^2 overflows.
   assign check_exit = (count_ff >= max_iter_ff) || alu_res.nan;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_INIT_R;
         ST_INIT_R: state_in = ST_INIT_I;
         ST_INIT_I: state_in = ST_CHECK;
         ST_CHECK:  state_in = check_exit ? ST_IDLE : ST_DIFF;
         ST_DIFF:   state_in = ST_DSQ;
         ST_DSQ:    state_in = ST_T1;
         ST_T1:     state_in = ST_T2;
         ST_T2:     state_in = ST_ZI;
         ST_ZI:     state_in = ST_R1;
         ST_R1:     state_in = ST_ZR;
         ST_ZR:     state_in = ST_SQR;
         ST_SQR:    state_in = ST_SQI;
         ST_SQI:    state_in = ST_CHECK;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Operation and operands for the shared unit
   always_comb begin
      alu_req.op = ALU_ADD;
      alu_req.a  = t_ff;
      alu_req.b  = t_ff;
      case (state_ff)
         ST_INIT_R, ST_SQR: begin
            alu_req.op = ALU_SQUARE;
            alu_req.a  = zr_ff;
         end
         ST_INIT_I, ST_SQI: begin
            alu_req.op = ALU_SQUARE;
            alu_req.a  = zi_ff;
         end
         ST_CHECK: begin
            alu_req.a = zr2_ff;
            alu_req.b = zi2_ff;
         end
         // x - y, squared next for the 2xy identity
         ST_DIFF: begin
            alu_req.a = zr_ff;
            alu_req.b = sm_negate(zi_ff);
         end
         ST_DSQ: begin
            alu_req.op = ALU_SQUARE;
            alu_req.a  = t_ff;
         end
         ST_T1: begin
            alu_req.a = sm_negate(t_ff);
            alu_req.b = zr2_ff;
         end
         ST_T2: begin
            alu_req.a = t_ff;
            alu_req.b = zi2_ff;
         end
         ST_ZI: begin
            alu_req.a = t_ff;
            alu_req.b = ci_ff;
         end
         ST_R1: begin
            alu_req.a = zr2_ff;
            alu_req.b = sm_negate(zi2_ff);
         end
         ST_ZR: begin
            alu_req.a = t_ff;
            alu_req.b = cr_ff;
         end
         default: begin
            alu_req.op = ALU_ADD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_iter_ff  <= MAX_ITER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_CHECK) && check_exit;
         if (csr_we) begin
            max_iter_ff <= csr_wdata;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            // Load the item; hold it while not started
            if (start) begin
               cr_ff    <= sm_decode(req_item.c_real);
               ci_ff    <= sm_decode(req_item.c_imag);
               zr_ff    <= sm_decode(req_item.z_real);
               zi_ff    <= sm_decode(req_item.z_imag);
               count_ff <= '0;
            end
         end
         ST_INIT_R, ST_SQR: zr2_ff <= alu_res;
         ST_INIT_I:         zi2_ff <= alu_res;
         ST_SQI: begin
            zi2_ff   <= alu_res;
            count_ff <= count_ff + COUNT_BITS'(1);
         end
         ST_CHECK: begin
            if (check_exit) begin
               rsp_item_ff.iteration_count <= count_ff;
               rsp_item_ff.glyph_code      <= glyph_for(count_ff);
            end
         end
         ST_DIFF, ST_DSQ, ST_T1, ST_T2, ST_R1: t_ff <= alu_res;
         ST_ZI:   zi_ff <= alu_res;
         ST_ZR:   zr_ff <= alu_res;
         default: t_ff  <= t_ff;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> rtl/core/fei_checker.sv
`timescale 1ns / 1ps
`include "fractal_escape_iteration_unit_macros.svh"

module fei_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input fei_pkg::rsp_type rsp_item
);
   import fei_pkg::*;

   // An accepted item keeps the unit busy on the next cycle.
   `FEI_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised after accept")

   // A result comes out as the unit goes idle.
   `FEI_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")

   // The strobe lasts a single cycle.
   `FEI_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe repeated")

   // Low counts map to a blank glyph.
   `FEI_ASSERT_NOW(a_glyph_blank, clock, reset, rsp_valid && (rsp_item.iteration_count < 8'd6), rsp_item.glyph_code == GLYPH_SPACE, "glyph not blank for low count")

   // The glyph is always printable.
   `FEI_ASSERT_NOW(a_glyph_range, clock, reset, rsp_valid, (rsp_item.glyph_code >= 7'd32) && (rsp_item.glyph_code <= 7'd126), "glyph not printable")

endmodule

bind fractal_escape_iteration_unit fei_checker u_checker (.*);

>>> tb/tb_fractal_escape_iteration_unit.sv
`timescale 1ns / 1ps

module tb_fractal_escape_iteration_unit;

   localparam int unsigned FIELD_W      = fei_pkg::FIELD_BITS;
   localparam int unsigned MAG_W        = fei_pkg::MAG_BITS;
   localparam int unsigned MAG_TOP      = (1 << MAG_W) - 1;
   localparam int unsigned ONE          = 1 << fei_pkg::FRAC_BITS;
   localparam int unsigned ROUND_HALF   = 1 << (fei_pkg::FRAC_BITS - 1);
   localparam int unsigned GLYPH_OFFSET = 3;
   localparam int unsigned DRAIN_GUARD  = 6000;
   localparam int unsigned TAIL_CYCLES  = 40;
   localparam int unsigned PRINT_CAP    = 100;
   localparam int unsigned PHASE_COUNT  = 8;
   localparam int unsigned PHASE_ITEMS  = 72;

   // Sign-magnitude number with an overflow flag, as the datapath carries it.
   typedef struct packed {
      logic             ovf;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } sm_num;

   // Escape-time predictor plus the queue of results still owed by the block.
   class escape_scoreboard;
      logic [7:0]       iter_limit;
      fei_pkg::rsp_type pending[$];
      int unsigned      fail_count;
      string            palette;

      function new();
         iter_limit = fei_pkg::MAX_ITER_RESET;
         fail_count = 0;
         palette    = " .,'~=+:;[/<*?&o0x#";
      endfunction

      function sm_num overflowed();
         sm_num r;
         r     = '0;
         r.ovf = 1'b1;
         return r;
      endfunction

      function sm_num field_value(logic [FIELD_W-1:0] bits);
         sm_num r;
         r.ovf = 1'b0;
         r.neg = bits[MAG_W];
         r.mag = bits[MAG_W-1:0];
         return r;
      endfunction

      function sm_num flip(sm_num a);
         sm_num r;
         r     = a;
         r.neg = ~a.neg;
         return r;
      endfunction

      // Round to nearest on the fraction; anything past the magnitude range overflows.
      function sm_num square(sm_num a);
         sm_num       r;
         int unsigned m;
         int unsigned p;
         if (a.ovf) return overflowed();
         m = a.mag;
         p = (m * m + ROUND_HALF) >> fei_pkg::FRAC_BITS;
         if (p > MAG_TOP) return overflowed();
         r     = '0;
         r.mag = p[MAG_W-1:0];
         return r;
      endfunction

      // On a tie of unlike signs the first operand keeps its sign.
      function sm_num add(sm_num a, sm_num b);
         sm_num       r;
         int unsigned s;
         if (a.ovf || b.ovf) return overflowed();
         r = '0;
         if (a.neg == b.neg) begin
            s = int'(a.mag) + int'(b.mag);
            if (s > MAG_TOP) return overflowed();
            r.mag = s[MAG_W-1:0];
            r.neg = a.neg;
         end else if (a.mag < b.mag) begin
            r.mag = b.mag - a.mag;
            r.neg = b.neg;
         end else begin
            r.mag = a.mag - b.mag;
            r.neg = a.neg;
         end
         return r;
      endfunction

      // 2xy as -(x-y)^2 + x^2 + y^2, summed strictly left to right.
      function sm_num twice_product(sm_num x, sm_num y);
         sm_num xx;
         sm_num yy;
         sm_num dd;
         xx = square(x);
         if (xx.ovf) return overflowed();
         yy = square(y);
         if (yy.ovf) return overflowed();
         dd = square(add(x, flip(y)));
         return add(add(flip(dd), xx), yy);
      endfunction

      function logic [fei_pkg::GLYPH_BITS-1:0] glyph(int unsigned count);
         int unsigned  h;
         byte unsigned ch;
         h = count / 2;
         if (h < GLYPH_OFFSET) begin
            ch = palette.getc(0);
         end else if (h - GLYPH_OFFSET >= palette.len()) begin
            ch = palette.getc(palette.len() - 1);
         end else begin
            ch = palette.getc(h - GLYPH_OFFSET);
         end
         return ch[fei_pkg::GLYPH_BITS-1:0];
      endfunction

      function fei_pkg::rsp_type escape_result(fei_pkg::req_type it);
         sm_num            cr;
         sm_num            ci;
         sm_num            zr;
         sm_num            zi;
         sm_num            zr2;
         sm_num            zi2;
         sm_num            mod2;
         int unsigned      count;
         fei_pkg::rsp_type res;
         cr    = field_value(it.c_real);
         ci    = field_value(it.c_imag);
         zr    = field_value(it.z_real);
         zi    = field_value(it.z_imag);
         zr2   = square(zr);
         zi2   = square(zi);
         count = 0;
         forever begin
            mod2 = add(zr2, zi2);
            if (count >= iter_limit || mod2.ovf) break;
            // New zi uses the old zr; new zr needs only the old squares.
            zi  = add(twice_product(zr, zi), ci);
            zr  = add(add(zr2, flip(zi2)), cr);
            zr2 = square(zr);
            zi2 = square(zi);
            count++;
         end
         res.iteration_count = count[fei_pkg::COUNT_BITS-1:0];
         res.glyph_code      = glyph(count);
         return res;
      endfunction

      function void note_item(fei_pkg::req_type it);
         pending.push_back(escape_result(it));
      endfunction

      task report(string msg);
         fail_count++;
         if (fail_count <= PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
      endtask

      task check_result(fei_pkg::rsp_type got);
         fei_pkg::rsp_type want;
         if (pending.size() == 0) begin
            report($sformatf("result count=%0d glyph=%02h with no item pending",
                             got.iteration_count, got.glyph_code));
         end else begin
            want = pending.pop_front();
            if (got.iteration_count !== want.iteration_count)
               report($sformatf("iteration_count %0d, expected %0d",
                                got.iteration_count, want.iteration_count));
            if (got.glyph_code !== want.glyph_code)
               report($sformatf("glyph_code %02h, expected %02h",
                                got.glyph_code, want.glyph_code));
         end
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   fei_pkg::req_type req_item;
   logic             rsp_valid;
   fei_pkg::rsp_type rsp_item;
   logic             csr_we;
   logic [7:0]       csr_wdata;

   escape_scoreboard sb;

   fractal_escape_iteration_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Check every strobed result against the oldest prediction.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) sb.check_result(rsp_item);
   end

   // Hard stop in case the block hangs.
   initial begin
      #(50_000_000);
      $display("tb: failure");
      $finish;
   end

   function automatic logic [FIELD_W-1:0] part(bit neg, logic [31:0] mag);
      return {neg, mag[MAG_W-1:0]};
   endfunction

   // Mostly short gaps, a few long ones; zero keeps start high back to back.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   // Bias toward points near the set so counts spread over the whole range.
   function automatic fei_pkg::req_type random_item();
      fei_pkg::req_type it;
      logic [63:0]      raw;
      int unsigned      mode;
      mode = $urandom_range(0, 9);
      raw  = {$urandom, $urandom};
      it   = raw[$bits(fei_pkg::req_type)-1:0];
      if (mode < 4) begin
         // Classic set: start at (signed) zero.
         it.c_real = part(raw[48], $urandom_range(0, 5 * ONE / 2));
         it.c_imag = part(raw[49], $urandom_range(0, 5 * ONE / 4));
         it.z_real = part(raw[50], 0);
         it.z_imag = part(raw[51], 0);
      end else if (mode < 7) begin
         // Julia style: small c, start anywhere in the escape disk.
         it.c_real = part(raw[48], $urandom_range(0, ONE));
         it.c_imag = part(raw[49], $urandom_range(0, ONE));
         it.z_real = part(raw[50], $urandom_range(0, 7 * ONE / 4));
         it.z_imag = part(raw[51], $urandom_range(0, 7 * ONE / 4));
      end
      return it;
   endfunction

   // Present one item and hold it until the block takes it.
   task automatic send_item(fei_pkg::req_type it);
      @(negedge clock);
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_item(it);
   endtask

   // Drop start for a while, or keep it up for a back-to-back item.
   task automatic pause(bit steady);
      int unsigned gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_parts(logic [FIELD_W-1:0] cr, logic [FIELD_W-1:0] ci,
                             logic [FIELD_W-1:0] zr, logic [FIELD_W-1:0] zi);
      fei_pkg::req_type it;
      it.c_real = cr;
      it.c_imag = ci;
      it.z_real = zr;
      it.z_imag = zi;
      send_item(it);
      pause(1'b0);
   endtask

   // Release start and wait for every owed result; leftovers count as failures.
   task automatic wait_results_done();
      int unsigned guard;
      @(negedge clock);
      start <= 1'b0;
      guard = 0;
      while (sb.pending.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      if (sb.pending.size() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.pending.size()));
         sb.pending.delete();
      end
   endtask

   // The block is idle here: every item has produced its result.
   task automatic write_iter_limit(logic [7:0] value);
      wait_results_done();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.iter_limit = value;
   endtask

   task automatic directed_items();
      // Reset limit of 250: origin, all ones, real-axis and imaginary landmarks.
      send_parts(part(0, 0), part(0, 0), part(0, 0), part(0, 0));
      send_parts('1, '1, '1, '1);
      send_parts(part(1, 2 * ONE), part(0, 0), part(0, 0), part(0, 0));
      send_parts(part(0, ONE / 4), part(0, 0), part(0, 0), part(0, 0));
      send_parts(part(1, 3 * ONE / 4), part(0, 0), part(0, 0), part(0, 0));
      send_parts(part(0, ONE), part(0, 0), part(0, 0), part(0, 0));
      send_parts(part(0, 0), part(0, ONE), part(0, 0), part(0, 0));
      send_parts(part(1, 0), part(1, ONE), part(1, 0), part(1, 0));
      send_parts(part(1, 0), part(1, 0), part(1, 0), part(1, 0));
      send_parts(part(1, 205), part(0, 40), part(0, ONE / 2), part(1, ONE / 2));
      // Opposite signs of equal size, then equal parts so x - y cancels.
      send_parts(part(0, 0), part(0, 0), part(0, ONE), part(1, ONE));
      send_parts(part(0, 0), part(0, 0), part(0, ONE / 2), part(0, ONE / 2));
      // Largest square that fits, and the first one that overflows.
      send_parts(part(0, 0), part(0, 0), part(0, 723), part(0, 0));
      send_parts(part(0, 0), part(0, 0), part(0, 724), part(0, 0));
      // Sum of squares just over and just under the range.
      send_parts(part(0, 0), part(0, 0), part(0, 2 * ONE), part(0, 2 * ONE));
      send_parts(part(0, 0), part(0, 0), part(0, 2 * ONE), part(1, 2 * ONE - 1));
      send_parts(part(0, MAG_TOP), part(0, MAG_TOP), part(0, 0), part(0, 0));
      send_parts(part(1, MAG_TOP), part(1, MAG_TOP), part(1, 0), part(0, 0));

      // Zero limit: no iteration at all.
      write_iter_limit(8'd0);
      send_parts('1, '1, '1, '1);
      send_parts(part(0, 0), part(0, 0), part(0, 0), part(0, 0));
      send_parts(part(1, 2 * ONE), part(0, 0), part(0, 0), part(0, 0));

      write_iter_limit(8'd1);
      send_parts(part(0, 0), part(0, 0), part(0, 0), part(0, 0));
      send_parts(part(0, ONE), part(0, 0), part(0, 0), part(0, 0));

      // Top limit: a bounded orbit runs out the full count.
      write_iter_limit(8'hFF);
      send_parts(part(0, 0), part(0, 0), part(0, 0), part(0, 0));
      send_parts(part(1, ONE), part(0, 0), part(0, 0), part(0, 0));
   endtask

   initial begin
      logic [7:0]  limit;
      bit          steady;
      sb        = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      directed_items();

      // Random phases, each under its own limit; one runs with no idling.
      for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
         steady = 1'b0;
         case (ph)
            0: limit = 8'hFF;
            1: limit = 8'd1;
            2: limit = 8'd0;
            3: limit = 8'($urandom_range(2, 30));
            4: begin
               limit  = fei_pkg::MAX_ITER_RESET;
               steady = 1'b1;
            end
            6: limit = 8'd64;
            default: limit = 8'($urandom_range(1, 255));
         endcase
         write_iter_limit(limit);
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            send_item(random_item());
            pause(steady);
         end
      end

      // Drain, then watch a little longer for stray strobes.
      wait_results_done();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
